// ===== rtl/fifo_queue_with_search_core_defines.svh =====
// Assertion macros used by the queue sequencer.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef FIFO_QUEUE_WITH_SEARCH_CORE_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_CORE_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define FQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition in one cycle that implies a consequence in the next one.
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fqs_pkg.sv =====
// Shared types and constants of the queue with search.
// No dependencies.
package fqs_pkg;

  localparam int unsigned FQS_DEPTH   = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OUT_CNT_W   = 5;
  localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

  // Operation codes carried by each item.
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SEARCH = 2'd3
  } fqs_op_e;

  // Result of one item, handed from the sequencer to the output register.
  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic                     is_empty;
    logic [OUT_CNT_W-1:0]     entry_count;
    logic                     found;
    logic                     push_dropped;
  } fqs_result_t;

endpackage

// ===== rtl/fifo_queue_with_search_core.sv =====
// Queue of signed 32-bit values with push, pop, clear and search.
// Push, clear, pop to empty and search on an empty queue go straight to the result
// state; pop first fetches the new head from the slot memory; a search compares up
// to DEPTH entries, one read of the slot memory per entry, and stops at the first match.
// The next item is accepted only when the previous result moves into the output register.
// Reset clears pointers and count at once; the slot memory is never cleared.
module fifo_queue_with_search_core import fqs_pkg::*; #(
  parameter int unsigned DEPTH = FQS_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic signed [DATA_W-1:0]    push_value_i,
  input  logic signed [DATA_W-1:0]    search_key_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [DATA_W-1:0]    front_value_o,
  output logic signed [DATA_W-1:0]    back_value_o,
  output logic                        is_empty_o,
  output logic [OUT_CNT_W-1:0]        entry_count_o,
  output logic                        found_o,
  output logic                        push_dropped_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                     res_valid;
  logic                     res_ready;
  fqs_result_t              res;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [IDX_W-1:0]         mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;
  logic                     out_valid_q, out_valid_d;
  fqs_result_t              out_q;

  fqs_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .push_value_i (push_value_i),
    .search_key_i (search_key_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  fqs_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign front_value_o  = out_q.front_value;
  assign back_value_o   = out_q.back_value;
  assign is_empty_o     = out_q.is_empty;
  assign entry_count_o  = out_q.entry_count;
  assign found_o        = out_q.found;
  assign push_dropped_o = out_q.push_dropped;

endmodule

// ===== rtl/fqs_ram.sv =====
// Slot memory of the queue: one write port, one read port, registered read data.
// Depends on fqs_pkg.
module fqs_ram import fqs_pkg::*; #(
  parameter int unsigned DEPTH = FQS_DEPTH,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [IDX_W-1:0]         waddr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [IDX_W-1:0]         raddr_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data, loaded while the read enable is high.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fqs_ctrl.sv =====
// Sequencer of the queue: ring pointers, entry count, head and tail copies,
// and the search walk over the slot memory. Depends on fqs_pkg and the defines header.
`include "fifo_queue_with_search_core_defines.svh"
module fqs_ctrl import fqs_pkg::*; #(
  parameter int unsigned DEPTH = FQS_DEPTH,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               func_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  input  logic signed [DATA_W-1:0] search_key_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output fqs_result_t              res_o,
  output logic                     mem_we_o,
  output logic [IDX_W-1:0]         mem_waddr_o,
  output logic signed [DATA_W-1:0] mem_wdata_o,
  output logic                     mem_re_o,
  output logic [IDX_W-1:0]         mem_raddr_o,
  input  logic signed [DATA_W-1:0] mem_rdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_POP_RD = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_RESULT = 4'b1000
  } fqs_state_e;

  fqs_state_e state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] scan_ptr_q, scan_ptr_d;
  logic [CNT_W-1:0] scan_left_q, scan_left_d;
  logic             found_q, found_d;
  logic             dropped_q, dropped_d;
  logic signed [DATA_W-1:0] front_q, front_d;
  logic signed [DATA_W-1:0] back_q, back_d;
  logic signed [DATA_W-1:0] key_q, key_d;

  fqs_op_e          op;
  logic             ready_for_item;
  logic             accept;
  logic             is_full;
  logic             is_void;
  logic             match;
  logic [IDX_W-1:0] head_nxt;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(DEPTH - 1)) begin
      return '0;
    end else begin
      return idx + 1'b1;
    end
  endfunction

  // Handshake and status decode.
  assign op             = fqs_op_e'(func_i);
  assign ready_for_item = (state_q == ST_IDLE) || ((state_q == ST_RESULT) && res_ready_i);
  assign in_stall_o     = !ready_for_item;
  assign accept         = in_valid_i && ready_for_item;
  assign is_full        = (count_q == CNT_W'(DEPTH));
  assign is_void        = (count_q == '0);
  assign match          = (mem_rdata_i == key_q);
  assign head_nxt       = ring_next(head_q);

  // Next state, pointer updates and memory requests.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    scan_ptr_d  = scan_ptr_q;
    scan_left_d = scan_left_q;
    found_d     = found_q;
    dropped_d   = dropped_q;
    front_d     = front_q;
    back_d      = back_q;
    key_d       = key_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_q;
    mem_wdata_o = push_value_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = scan_ptr_q;

    unique case (state_q) inside
      ST_IDLE, ST_RESULT: begin
        if ((state_q == ST_RESULT) && res_ready_i) begin
          state_d = ST_IDLE;
        end
        if (accept) begin
          found_d   = 1'b0;
          dropped_d = 1'b0;
          key_d     = search_key_i;
          state_d   = ST_RESULT;
          unique case (op)
            OP_PUSH: begin
              if (is_full) begin
                dropped_d = 1'b1;
              end else begin
                mem_we_o = 1'b1;
                tail_d   = ring_next(tail_q);
                count_d  = count_q + 1'b1;
                back_d   = push_value_i;
                if (is_void) begin
                  front_d = push_value_i;
                end
              end
            end
            OP_POP: begin
              if (!is_void) begin
                head_d  = head_nxt;
                count_d = count_q - 1'b1;
                // The new head must be fetched unless the queue runs empty.
                if (count_q != CNT_W'(1)) begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = head_nxt;
                  state_d     = ST_POP_RD;
                end
              end
            end
            OP_CLEAR: begin
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
            end
            OP_SEARCH: begin
              if (!is_void) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                scan_ptr_d  = head_nxt;
                scan_left_d = count_q;
                state_d     = ST_SEARCH;
              end
            end
          endcase
        end
      end
      ST_POP_RD: begin
        front_d = mem_rdata_i;
        state_d = ST_RESULT;
      end
      ST_SEARCH: begin
        // Compare the entry fetched last cycle; fetch the next one unless this one matched or was the last.
        if (match || (scan_left_q == CNT_W'(1))) begin
          found_d = match;
          state_d = ST_RESULT;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = scan_ptr_q;
          scan_ptr_d  = ring_next(scan_ptr_q);
          scan_left_d = scan_left_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      scan_ptr_q  <= '0;
      scan_left_q <= '0;
      found_q     <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      scan_ptr_q  <= scan_ptr_d;
      scan_left_q <= scan_left_d;
      found_q     <= found_d;
      dropped_q   <= dropped_d;
    end
  end

  // Payload registers: head and tail copies and the search key.
  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
    key_q   <= key_d;
  end

  // Result of the finished item.
  assign res_valid_o           = (state_q == ST_RESULT);
  assign res_o.front_value     = is_void ? EMPTY_MARK : front_q;
  assign res_o.back_value      = is_void ? EMPTY_MARK : back_q;
  assign res_o.is_empty        = is_void;
  assign res_o.entry_count     = OUT_CNT_W'(count_q);
  assign res_o.found           = found_q;
  assign res_o.push_dropped    = dropped_q;

  // Expected tail from head and count, for the ring check below.
  logic [CNT_W:0]   ring_sum;
  logic [IDX_W-1:0] ring_tail_exp;
  always_comb begin
    ring_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
    if (ring_sum >= (CNT_W + 1)'(DEPTH)) begin
      ring_sum = ring_sum - (CNT_W + 1)'(DEPTH);
    end
    ring_tail_exp = IDX_W'(ring_sum);
  end

  `FQS_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count exceeds depth")
  `FQS_ASSERT(a_ring_consistent, ring_tail_exp == tail_q, "tail does not match head plus count")
  `FQS_ASSERT_NEXT(a_full_push_kept, accept && (op == OP_PUSH) && is_full, $stable(count_q) && dropped_q, "push into full queue changed state")
  `FQS_ASSERT(a_write_on_accept, mem_we_o |-> accept, "slot written without an accepted push")
  `FQS_ASSERT_NEXT(a_read_consumed, mem_re_o, (state_q == ST_POP_RD) || (state_q == ST_SEARCH), "read data arrives with nobody to take it")

endmodule

// ===== dv/tb_fifo_queue_with_search_core.sv =====
// Testbench for fifo_queue_with_search_core: directed corner cases, then random traffic.
// Depends on fqs_pkg and the core RTL. Results are checked against a predictor of its own.
module tb_fifo_queue_with_search_core import fqs_pkg::*;;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               func_i = OP_POP;
  logic signed [DATA_W-1:0] push_value_i = '0;
  logic signed [DATA_W-1:0] search_key_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] front_value_o;
  logic signed [DATA_W-1:0] back_value_o;
  logic                     is_empty_o;
  logic [OUT_CNT_W-1:0]     entry_count_o;
  logic                     found_o;
  logic                     push_dropped_o;

  // Predicted queue contents and the results still owed by the block.
  logic signed [DATA_W-1:0] model_slots [FQS_DEPTH];
  int unsigned              model_head = 0;
  int unsigned              model_tail = 0;
  int unsigned              model_count = 0;
  fqs_result_t              pending_results [$];

  // Idling controls shared by the test tasks and the stall process.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_cycles = 0;
  int unsigned mismatch_count = 0;

  fifo_queue_with_search_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .push_value_i   (push_value_i),
    .search_key_i   (search_key_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o),
    .is_empty_o     (is_empty_o),
    .entry_count_o  (entry_count_o),
    .found_o        (found_o),
    .push_dropped_o (push_dropped_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one operation to the predicted queue and return the result it yields.
  function automatic fqs_result_t next_queue_result(fqs_op_e op,
                                                    logic signed [DATA_W-1:0] value,
                                                    logic signed [DATA_W-1:0] key);
    fqs_result_t r;
    int unsigned idx;
    r.found = 1'b0;
    r.push_dropped = 1'b0;
    case (op)
      OP_PUSH: begin
        if (model_count >= FQS_DEPTH) begin
          r.push_dropped = 1'b1;
        end else begin
          model_slots[model_tail] = value;
          model_tail = (model_tail + 1) % FQS_DEPTH;
          model_count++;
        end
      end
      OP_POP: begin
        if (model_count != 0) begin
          model_head = (model_head + 1) % FQS_DEPTH;
          model_count--;
        end
      end
      OP_CLEAR: begin
        model_head = 0;
        model_tail = 0;
        model_count = 0;
      end
      OP_SEARCH: begin
        idx = model_head;
        for (int k = 0; k < model_count; k++) begin
          if (model_slots[idx] == key) r.found = 1'b1;
          idx = (idx + 1) % FQS_DEPTH;
        end
      end
      default: ;
    endcase
    if (model_count == 0) begin
      r.front_value = EMPTY_MARK;
      r.back_value = EMPTY_MARK;
      r.is_empty = 1'b1;
    end else begin
      r.front_value = model_slots[model_head];
      r.back_value = model_slots[(model_tail + FQS_DEPTH - 1) % FQS_DEPTH];
      r.is_empty = 1'b0;
    end
    r.entry_count = OUT_CNT_W'(model_count);
    return r;
  endfunction

  // Mostly ordinary values, with small ones for repeats and the signed extremes.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $signed($urandom_range(15)) - 8;
      1: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // When entries are held, half the keys are taken from them, so searches hit often.
  function automatic logic signed [DATA_W-1:0] pick_key();
    if (model_count != 0 && $urandom_range(1) == 1) begin
      return model_slots[(model_head + $urandom_range(model_count - 1)) % FQS_DEPTH];
    end
    return pick_value();
  endfunction

  // The mix favors filling, draining or neither, so the queue swings between empty and full.
  function automatic fqs_op_e choose_op(int unsigned mix);
    int unsigned roll;
    int unsigned push_lim;
    int unsigned pop_lim;
    roll = $urandom_range(99);
    case (mix)
      0: begin push_lim = 60; pop_lim = 72; end
      1: begin push_lim = 20; pop_lim = 65; end
      default: begin push_lim = 35; pop_lim = 60; end
    endcase
    if (roll < push_lim) return OP_PUSH;
    if (roll < pop_lim) return OP_POP;
    if (roll < 97) return OP_SEARCH;
    return OP_CLEAR;
  endfunction

  // Offer one item, wait until it is taken, and record what it should produce.
  // Called and returning at a falling edge; valid stays high for a following item.
  task automatic send_item(fqs_op_e op, logic signed [DATA_W-1:0] value,
                           logic signed [DATA_W-1:0] key);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= op;
    push_value_i <= value;
    search_key_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(next_queue_result(op, value, key));
    @(negedge clk_i);
  endtask

  function automatic void report_mismatch(string what, logic [DATA_W-1:0] want,
                                          logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at %0t: %s expected %h, got %h", $realtime, what, want, got);
    end
  endfunction

  // The receiver stalls at random, or for a whole stretch while a hold-off runs.
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      rx_hold_cycles--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Compare every accepted result with the oldest outstanding prediction.
  always @(posedge clk_i) begin : check_results
    fqs_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, front_value", '0, front_value_o);
      end else begin
        want = pending_results.pop_front();
        if (front_value_o !== want.front_value)
          report_mismatch("front_value", want.front_value, front_value_o);
        if (back_value_o !== want.back_value)
          report_mismatch("back_value", want.back_value, back_value_o);
        if (is_empty_o !== want.is_empty)
          report_mismatch("is_empty", DATA_W'(want.is_empty), DATA_W'(is_empty_o));
        if (entry_count_o !== want.entry_count)
          report_mismatch("entry_count", DATA_W'(want.entry_count),
                          DATA_W'(entry_count_o));
        if (found_o !== want.found)
          report_mismatch("found", DATA_W'(want.found), DATA_W'(found_o));
        if (push_dropped_o !== want.push_dropped)
          report_mismatch("push_dropped", DATA_W'(want.push_dropped),
                          DATA_W'(push_dropped_o));
      end
    end
  end

  // Pop, search and clear while nothing is held.
  task automatic test_empty_queue_ops();
    send_item(OP_POP, pick_value(), pick_value());
    send_item(OP_SEARCH, pick_value(), '0);
    send_item(OP_CLEAR, pick_value(), pick_value());
  endtask

  // Signed extremes, and a stored value equal to the empty marker.
  task automatic test_extreme_values();
    send_item(OP_PUSH, 32'sh8000_0000, '0);
    send_item(OP_SEARCH, '0, 32'sh8000_0000);
    send_item(OP_PUSH, 32'sh7fff_ffff, '0);
    send_item(OP_SEARCH, '1, 32'sh7fff_ffff);
    send_item(OP_SEARCH, '0, 32'sh0001_2345);
    send_item(OP_POP, '1, '1);
    send_item(OP_PUSH, '1, '0);
    send_item(OP_SEARCH, '0, '1);
  endtask

  // Fill the queue, push into it while full, search for the newest entry, then empty it again.
  task automatic test_full_queue();
    while (model_count < FQS_DEPTH) send_item(OP_PUSH, pick_value(), pick_value());
    send_item(OP_PUSH, 32'sd7, '0);
    send_item(OP_SEARCH, '0, model_slots[(model_tail + FQS_DEPTH - 1) % FQS_DEPTH]);
    send_item(OP_POP, '0, '0);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_POP, '0, '0);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the input stalls.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_cycles = 300;
    for (int i = 0; i < 30; i++) send_item(choose_op(0), pick_value(), pick_key());
  endtask

  task automatic test_random_traffic(int unsigned n_items, int unsigned tx_pct,
                                     int unsigned rx_pct);
    int unsigned mix;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    mix = 2;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) mix = $urandom_range(2);
      send_item(choose_op(mix), pick_value(), pick_key());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_queue_ops();
    test_extreme_values();
    test_full_queue();
    test_backpressure();
    test_random_traffic(225, 0, 0);
    test_random_traffic(225, 77, 0);
    test_random_traffic(225, 0, 77);
    test_random_traffic(225, 21, 21);
    in_valid_i <= 1'b0;

    // Drain what is still owed, then watch a while for stray results.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (FQS_DEPTH + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #800000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== fifo_queue_with_search_core.f =====
+incdir+rtl
rtl/fqs_pkg.sv
rtl/fqs_ram.sv
rtl/fqs_ctrl.sv
rtl/fifo_queue_with_search_core.sv
dv/tb_fifo_queue_with_search_core.sv
